@@ src/epc_pkg.sv @@
// ----------------------------------------------------------------------------
// epc_pkg: shared types and constants of the encoder parameter controller
// Holds the command format passed from the front end to the back end, the
// direction and index codes, setting bounds and the resolution tick table.
// ----------------------------------------------------------------------------
package epc_pkg;

  // Default number of channel pattern slots.
  localparam int NUM_CHANNELS_DEF = 4;

  // Quadrature history patterns.
  localparam logic [3:0] PAT_HI = 4'b1001;
  localparam logic [3:0] PAT_LO = 4'b0011;

  // Setting bounds.
  localparam logic [9:0] TEMPO_MAX = 10'd999;
  localparam logic [9:0] TEMPO_MIN = 10'd20;
  localparam logic [9:0] TEMPO_RST = 10'd120;
  localparam logic [3:0] TOP4      = 4'd15;
  localparam logic [3:0] RES_MAX   = 4'd8;

  // Tempo step values.
  localparam logic [4:0] STEP_1  = 5'd1;
  localparam logic [4:0] STEP_5  = 5'd5;
  localparam logic [4:0] STEP_10 = 5'd10;
  localparam logic [4:0] STEP_20 = 5'd20;

  // Direction codes.
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  // Encoder and button index codes.
  localparam logic [2:0] IDX_TEMPO   = 3'd0;
  localparam logic [2:0] IDX_RES     = 3'd1;
  localparam logic [2:0] IDX_PAGE    = 3'd2;
  localparam logic [2:0] IDX_PATTERN = 3'd3;

  // Request from the front end to the back end.
  typedef struct packed {
    logic       button;
    logic [2:0] idx;
    logic [1:0] dir;
  } cmd_t;

  // Saturating 4-bit step up or down.
  function automatic logic [3:0] bump4(logic [3:0] v, logic up);
    logic [3:0] r;
    r = v;
    if (up) begin
      if (v < TOP4) r = v + 4'd1;
    end else begin
      if (v != 4'd0) r = v - 4'd1;
    end
    return r;
  endfunction

  // Resolution index to ticks per beat.
  function automatic logic [5:0] ticks_of(logic [3:0] res);
    logic [5:0] t;
    case (res)
      4'd0:    t = 6'd1;
      4'd1:    t = 6'd2;
      4'd2:    t = 6'd4;
      4'd3:    t = 6'd6;
      4'd4:    t = 6'd8;
      4'd5:    t = 6'd12;
      4'd6:    t = 6'd16;
      4'd7:    t = 6'd24;
      4'd8:    t = 6'd32;
      default: t = 6'd1;
    endcase
    return t;
  endfunction

endpackage

@@ src/epc_front.sv @@
// ----------------------------------------------------------------------------
// epc_front: input front end
// Accepts requests, shifts pin samples into the shared A/B histories and
// classifies each request into a command for the back end.
// ----------------------------------------------------------------------------
module epc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_button,
  input  logic [2:0]        req_idx,
  input  logic              req_pin_a,
  input  logic              req_pin_b,
  output logic              push_valid,
  input  logic              push_ready,
  output epc_pkg::cmd_t     push_cmd
);

  logic [3:0] a_hist_r, a_hist_nxt;
  logic [3:0] b_hist_r, b_hist_nxt;
  logic       take;

  assign in_ready   = push_ready;
  assign take       = in_valid && push_ready;
  assign push_valid = in_valid;

  // History update; button presses leave the histories alone.
  always_comb begin
    a_hist_nxt = a_hist_r;
    b_hist_nxt = b_hist_r;
    if (!req_button) begin
      a_hist_nxt = {a_hist_r[2:0], req_pin_a};
      b_hist_nxt = {b_hist_r[2:0], req_pin_b};
    end
  end

  // Classify the request into a command.
  always_comb begin
    push_cmd.button = req_button;
    push_cmd.idx    = req_idx;
    push_cmd.dir    = epc_pkg::DIR_NONE;
    if (!req_button) begin
      if (a_hist_nxt == epc_pkg::PAT_HI && b_hist_nxt == epc_pkg::PAT_LO) begin
        push_cmd.dir = epc_pkg::DIR_CW;
      end else if (a_hist_nxt == epc_pkg::PAT_LO && b_hist_nxt == epc_pkg::PAT_HI) begin
        push_cmd.dir = epc_pkg::DIR_CCW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_hist_r <= '0;
      b_hist_r <= '0;
    end else if (take) begin
      a_hist_r <= a_hist_nxt;
      b_hist_r <= b_hist_nxt;
    end
  end

endmodule

@@ src/epc_queue.sv @@
// ----------------------------------------------------------------------------
// epc_queue: two-entry command queue
// Decouples the front end from the back end so that each can stall alone.
// ----------------------------------------------------------------------------
module epc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  epc_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output epc_pkg::cmd_t pop_cmd
);

  epc_pkg::cmd_t mem_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Occupancy.
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

@@ src/epc_back.sv @@
// ----------------------------------------------------------------------------
// epc_back: settings back end
// Applies each command to the settings registers and loads the result
// register with the full set of values after the update.
// ----------------------------------------------------------------------------
module epc_back #(
  parameter int NUM_CHANNELS = epc_pkg::NUM_CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  epc_pkg::cmd_t pop_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   out_data
);

  localparam int RPT = (NUM_CHANNELS < 4) ? NUM_CHANNELS : 4;

  logic [9:0]  tempo_r, tempo_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [3:0]  res_r, res_nxt;
  logic [3:0]  page_r, page_nxt;
  logic [3:0]  loop_r, loop_nxt;
  logic        lsel_r, lsel_nxt;
  logic [3:0]  pat_r, pat_nxt;
  logic [3:0]  chan_r [NUM_CHANNELS];
  logic [3:0]  chan_nxt [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] mute_r, mute_nxt;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        do_pop;
  logic        mv, up;
  logic [10:0] sum, diff;
  logic [15:0] pats;
  logic [3:0]  mutes;

  assign pop_ready = !out_valid_r || out_ready;
  assign do_pop    = pop_valid && pop_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mv   = !pop_cmd.button && (pop_cmd.dir != epc_pkg::DIR_NONE);
  assign up   = (pop_cmd.dir == epc_pkg::DIR_CW);
  assign sum  = {1'b0, tempo_r} + {6'b0, step_r};
  assign diff = {1'b0, tempo_r} - {6'b0, step_r};

  // Next settings for the command at the head of the queue.
  always_comb begin
    tempo_nxt = tempo_r;
    step_nxt  = step_r;
    res_nxt   = res_r;
    page_nxt  = page_r;
    loop_nxt  = loop_r;
    lsel_nxt  = lsel_r;
    pat_nxt   = pat_r;
    mute_nxt  = mute_r;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      chan_nxt[c] = chan_r[c];
    end
    if (mv) begin
      case (pop_cmd.idx)
        epc_pkg::IDX_TEMPO: begin
          if (up) begin
            if (sum <= {1'b0, epc_pkg::TEMPO_MAX}) tempo_nxt = sum[9:0];
          end else begin
            if (!diff[10] && diff[9:0] >= epc_pkg::TEMPO_MIN) tempo_nxt = diff[9:0];
          end
        end
        epc_pkg::IDX_RES: begin
          if (up) begin
            if (res_r < epc_pkg::RES_MAX) res_nxt = res_r + 4'd1;
          end else begin
            if (res_r != 4'd0) res_nxt = res_r - 4'd1;
          end
        end
        epc_pkg::IDX_PAGE: begin
          if (lsel_r) loop_nxt = epc_pkg::bump4(loop_r, up);
          else        page_nxt = epc_pkg::bump4(page_r, up);
        end
        epc_pkg::IDX_PATTERN: begin
          pat_nxt = epc_pkg::bump4(pat_r, up);
        end
        default: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (c < 4 && pop_cmd.idx[1:0] == 2'(c)) begin
              chan_nxt[c] = epc_pkg::bump4(chan_r[c], up);
            end
          end
        end
      endcase
    end else if (pop_cmd.button) begin
      case (pop_cmd.idx)
        epc_pkg::IDX_TEMPO: begin
          case (step_r)
            epc_pkg::STEP_1:  step_nxt = epc_pkg::STEP_5;
            epc_pkg::STEP_5:  step_nxt = epc_pkg::STEP_10;
            epc_pkg::STEP_10: step_nxt = epc_pkg::STEP_20;
            epc_pkg::STEP_20: step_nxt = epc_pkg::STEP_1;
            default:          step_nxt = step_r;
          endcase
        end
        epc_pkg::IDX_PAGE: begin
          lsel_nxt = ~lsel_r;
        end
        default: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (pop_cmd.idx[2] && c < 4 && pop_cmd.idx[1:0] == 2'(c)) begin
              mute_nxt[c] = ~mute_r[c];
            end
          end
        end
      endcase
    end
  end

  // Reported channel patterns and mutes; absent channels read as zero.
  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_rpt
      if (g < RPT) begin : g_on
        assign pats[4*g +: 4] = chan_nxt[g];
        assign mutes[g]       = mute_nxt[g];
      end else begin : g_off
        assign pats[4*g +: 4] = 4'd0;
        assign mutes[g]       = 1'b0;
      end
    end
  endgenerate

  // Settings registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r <= epc_pkg::TEMPO_RST;
      step_r  <= epc_pkg::STEP_1;
      res_r   <= '0;
      page_r  <= '0;
      loop_r  <= '0;
      lsel_r  <= 1'b0;
      pat_r   <= '0;
      mute_r  <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        chan_r[c] <= '0;
      end
    end else if (do_pop) begin
      tempo_r <= tempo_nxt;
      step_r  <= step_nxt;
      res_r   <= res_nxt;
      page_r  <= page_nxt;
      loop_r  <= loop_nxt;
      lsel_r  <= lsel_nxt;
      pat_r   <= pat_nxt;
      mute_r  <= mute_nxt;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        chan_r[c] <= chan_nxt[c];
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_ready) begin
      out_valid_r <= pop_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (do_pop) begin
      out_data_r <= {4'b0, mutes, pats, pat_nxt, lsel_nxt, loop_nxt, page_nxt,
                     epc_pkg::ticks_of(res_nxt), res_nxt, step_nxt, tempo_nxt,
                     (pop_cmd.button ? epc_pkg::DIR_NONE : pop_cmd.dir)};
    end
  end

`ifndef SYNTHESIS
  a_tempo_range: assert property (@(posedge clk) disable iff (!rst_n)
    tempo_r >= epc_pkg::TEMPO_MIN && tempo_r <= epc_pkg::TEMPO_MAX)
    else $error("tempo left its range");

  a_step_set: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == epc_pkg::STEP_1 || step_r == epc_pkg::STEP_5 ||
    step_r == epc_pkg::STEP_10 || step_r == epc_pkg::STEP_20)
    else $error("tempo step outside its cycle");

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_r <= epc_pkg::RES_MAX)
    else $error("resolution index above its maximum");

  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> out_valid_r)
    else $error("popped request produced no result");
`endif

endmodule

@@ src/encoder_parameter_controller.sv @@
// ----------------------------------------------------------------------------
// encoder_parameter_controller: rotary encoder parameter controller
// Decodes quadrature pin samples and aux button presses into sequencer
// setting changes and reports all settings for every request.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one request per handshake. in_tuser[0] is 0 for an
//   encoder pin sample and 1 for an aux button press; in_tdata carries the
//   encoder or button index and the sampled A and B levels.
//   Output stream (out_*): exactly one result per request, in order, with
//   the step direction and every current setting after the update.
//   out_tvalid rises once its accepted request has passed through the queue
//   and the back end has loaded the result register.
//   Throughput is one request per cycle while out_tready stays high, set by
//   the settings update in the back end, which applies one command per pop.
//   A two-entry queue sits between the decoding front end and the settings
//   back end; when out_tready is low the result register holds, the queue
//   fills, and in_tready drops once the queue is full.
//   Reset (rst_n low, synchronous) empties the queue and result register,
//   clears the pin histories and restores tempo 120, step 1 and all other
//   settings to zero.
// ----------------------------------------------------------------------------
module encoder_parameter_controller #(
  parameter int NUM_CHANNELS = epc_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // encoder_index[2:0], pin_a[3], pin_b[4], zero[7:5]
  input  logic [0:0]  in_tuser,   // req_type[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // direction[1:0], tempo[11:2], tempo_step[16:12],
                                  // resolution_code[20:17], ticks_per_beat[26:21],
                                  // shown_page[30:27], loop_pages[34:31],
                                  // loop_selected[35], pattern_now[39:36],
                                  // channel_patterns[55:40], mute_mask[59:56]
);

  logic          push_valid, push_ready;
  logic          pop_valid, pop_ready;
  epc_pkg::cmd_t push_cmd, pop_cmd;

  // Request decode and pin histories.
  epc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .req_button (in_tuser[0]),
    .req_idx    (in_tdata[2:0]),
    .req_pin_a  (in_tdata[3]),
    .req_pin_b  (in_tdata[4]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Command queue.
  epc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Settings update and result register.
  epc_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the encoder parameter controller
// Drives pin samples and aux button presses through the request stream,
// predicts every settings report in its own model of the controller and
// compares each report field by field, with random gaps on both streams.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS     = epc_pkg::NUM_CHANNELS_DEF;
  localparam int CHAN_BASE    = 4;
  localparam int ITEM_TARGET  = 1100;
  localparam int SEGMENT_LEN  = 150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 8;

  localparam logic [5:0] TICKS_OF_RES [9] = '{6'd1, 6'd2, 6'd4, 6'd6, 6'd8,
                                              6'd12, 6'd16, 6'd24, 6'd32};

  // Report layout as packed in out_tdata, highest field first.
  typedef struct packed {
    logic [3:0]  spare;
    logic [3:0]  mutes;
    logic [15:0] chan_pats;
    logic [3:0]  pattern;
    logic        loop_sel;
    logic [3:0]  loop_pages;
    logic [3:0]  page;
    logic [5:0]  ticks;
    logic [3:0]  res_code;
    logic [4:0]  tempo_step;
    logic [9:0]  tempo;
    logic [1:0]  dir;
  } settings_report_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;

  // Predicted controller state.
  logic [3:0] hist_a, hist_b;
  logic [9:0] tempo_q;
  logic [4:0] step_q;
  logic [3:0] res_q, page_q, loop_q, pattern_q;
  logic       loop_sel_q;
  logic [3:0] chan_pat_q [CHANNELS];
  logic       mute_q [CHANNELS];

  settings_report_t pending_reports [$];

  int  mismatch_count = 0;
  int  requests_sent  = 0;
  int  reports_checked = 0;
  int  cw_steps = 0;
  int  ccw_steps = 0;
  int  tempo_low = 999;
  int  tempo_high = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  sender_idle = 1'b1;
  bit  receiver_idle = 1'b1;

  encoder_parameter_controller u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns clock.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Random idle length: mostly short, now and then long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Saturating 4-bit nudge.
  function automatic logic [3:0] nudge4(logic [3:0] v, logic up);
    if (up) return (v == 4'd15) ? v : v + 4'd1;
    return (v == 4'd0) ? v : v - 4'd1;
  endfunction

  function automatic void reset_prediction();
    hist_a     = '0;
    hist_b     = '0;
    tempo_q    = epc_pkg::TEMPO_RST;
    step_q     = epc_pkg::STEP_1;
    res_q      = '0;
    page_q     = '0;
    loop_q     = '0;
    loop_sel_q = 1'b0;
    pattern_q  = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      chan_pat_q[c] = '0;
      mute_q[c]     = 1'b0;
    end
  endfunction

  // Applies one request to the predicted state and returns the report it yields.
  function automatic settings_report_t predict_report(logic is_button, logic [2:0] idx,
                                                      logic pa, logic pb);
    settings_report_t r;
    logic [1:0] dir;
    logic up;
    int t, s, ch;
    dir = epc_pkg::DIR_NONE;
    ch  = int'(idx) - CHAN_BASE;
    if (!is_button) begin
      hist_a = {hist_a[2:0], pa};
      hist_b = {hist_b[2:0], pb};
      if (hist_a == epc_pkg::PAT_HI && hist_b == epc_pkg::PAT_LO) dir = epc_pkg::DIR_CW;
      else if (hist_a == epc_pkg::PAT_LO && hist_b == epc_pkg::PAT_HI) dir = epc_pkg::DIR_CCW;
      if (dir != epc_pkg::DIR_NONE) begin
        up = (dir == epc_pkg::DIR_CW);
        case (idx)
          epc_pkg::IDX_TEMPO: begin
            t = tempo_q;
            s = step_q;
            if (up) begin
              if (t + s <= epc_pkg::TEMPO_MAX) tempo_q = 10'(t + s);
            end else begin
              if (t - s >= epc_pkg::TEMPO_MIN) tempo_q = 10'(t - s);
            end
          end
          epc_pkg::IDX_RES: begin
            if (up && res_q < epc_pkg::RES_MAX) res_q = res_q + 4'd1;
            else if (!up && res_q != 4'd0) res_q = res_q - 4'd1;
          end
          epc_pkg::IDX_PAGE: begin
            if (loop_sel_q) loop_q = nudge4(loop_q, up);
            else page_q = nudge4(page_q, up);
          end
          epc_pkg::IDX_PATTERN: pattern_q = nudge4(pattern_q, up);
          default: begin
            if (ch >= 0 && ch < CHANNELS) chan_pat_q[ch] = nudge4(chan_pat_q[ch], up);
          end
        endcase
      end
    end else begin
      case (idx)
        epc_pkg::IDX_TEMPO: begin
          case (step_q)
            epc_pkg::STEP_1:  step_q = epc_pkg::STEP_5;
            epc_pkg::STEP_5:  step_q = epc_pkg::STEP_10;
            epc_pkg::STEP_10: step_q = epc_pkg::STEP_20;
            epc_pkg::STEP_20: step_q = epc_pkg::STEP_1;
            default:          step_q = step_q;
          endcase
        end
        epc_pkg::IDX_PAGE: loop_sel_q = ~loop_sel_q;
        default: begin
          // Buttons one and three do nothing; the rest toggle a channel mute.
          if (ch >= 0 && ch < CHANNELS) mute_q[ch] = ~mute_q[ch];
        end
      endcase
    end

    r            = '0;
    r.dir        = dir;
    r.tempo      = tempo_q;
    r.tempo_step = step_q;
    r.res_code   = res_q;
    r.ticks      = (res_q <= epc_pkg::RES_MAX) ? TICKS_OF_RES[res_q] : 6'd1;
    r.page       = page_q;
    r.loop_pages = loop_q;
    r.loop_sel   = loop_sel_q;
    r.pattern    = pattern_q;
    for (int c = 0; c < 4 && c < CHANNELS; c++) begin
      r.chan_pats[4*c +: 4] = chan_pat_q[c];
      r.mutes[c]            = mute_q[c];
    end
    return r;
  endfunction

  // Sends one request; the valid stays high on return until the next falling edge.
  task automatic send_request(input logic is_button, input logic [2:0] idx,
                              input logic pa, input logic pb);
    int gap;
    settings_report_t r;
    gap = sender_idle ? idle_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_button;
    in_tdata  <= {3'b000, pb, pa, idx};
    do @(posedge clk); while (!in_tready);
    r = predict_report(is_button, idx, pa, pb);
    pending_reports.push_back(r);
    requests_sent++;
    if (r.dir == epc_pkg::DIR_CW) cw_steps++;
    if (r.dir == epc_pkg::DIR_CCW) ccw_steps++;
    if (int'(r.tempo) < tempo_low) tempo_low = int'(r.tempo);
    if (int'(r.tempo) > tempo_high) tempo_high = int'(r.tempo);
  endtask

  // One full detent: four pin samples ending in a decoded step.
  task automatic turn_encoder(input logic [2:0] idx, input logic cw);
    for (int k = 3; k >= 0; k--)
      send_request(1'b0, idx, cw ? epc_pkg::PAT_HI[k] : epc_pkg::PAT_LO[k],
                   cw ? epc_pkg::PAT_LO[k] : epc_pkg::PAT_HI[k]);
  endtask

  task automatic press_button(input logic [2:0] idx);
    send_request(1'b1, idx, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic select_step(input logic [4:0] want);
    while (step_q != want) press_button(epc_pkg::IDX_TEMPO);
  endtask

  // Lowers the request valid and waits until every report has come back.
  task automatic wait_all_reports();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // Result stream backpressure.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (receiver_idle && $urandom_range(0, 3) == 0) stall_left = idle_gap();
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare every accepted report with the oldest prediction.
  always @(posedge clk) begin : report_checker
    settings_report_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = settings_report_t'(out_tdata);
      if (pending_reports.size() == 0) begin
        $error("report received with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        check_field("direction",        want.dir,        got.dir);
        check_field("tempo",            want.tempo,      got.tempo);
        check_field("tempo_step",       want.tempo_step, got.tempo_step);
        check_field("resolution_code",  want.res_code,   got.res_code);
        check_field("ticks_per_beat",   want.ticks,      got.ticks);
        check_field("shown_page",       want.page,       got.page);
        check_field("loop_pages",       want.loop_pages, got.loop_pages);
        check_field("loop_selected",    want.loop_sel,   got.loop_sel);
        check_field("pattern_now",      want.pattern,    got.pattern);
        check_field("channel_patterns", want.chan_pats,  got.chan_pats);
        check_field("mute_mask",        want.mutes,      got.mutes);
      end
    end
  end

  // Buttons one and three leave the reset settings untouched.
  task automatic test_reset_values();
    press_button(epc_pkg::IDX_RES);
    press_button(epc_pkg::IDX_PATTERN);
  endtask

  // Tempo, pattern, page and one channel encoder, the step, page and mute buttons, a saturated move and mutes.
  task automatic test_directed_operations();
    turn_encoder(epc_pkg::IDX_TEMPO, 1'b1);
    turn_encoder(epc_pkg::IDX_PATTERN, 1'b0);
    press_button(epc_pkg::IDX_TEMPO);
    press_button(epc_pkg::IDX_PAGE);
    turn_encoder(epc_pkg::IDX_PAGE, 1'b1);
    for (int b = CHAN_BASE; b < 8; b++) press_button(3'(b));
    turn_encoder(3'(CHAN_BASE + 3), 1'b1);
  endtask

  // Drives the tempo into both bounds with large and small steps.
  task automatic test_tempo_limits();
    select_step(epc_pkg::STEP_20);
    repeat (6) turn_encoder(epc_pkg::IDX_TEMPO, 1'b0);
    select_step(epc_pkg::STEP_1);
    turn_encoder(epc_pkg::IDX_TEMPO, 1'b0);
    select_step(epc_pkg::STEP_20);
    repeat (50) turn_encoder(epc_pkg::IDX_TEMPO, 1'b1);
    select_step(epc_pkg::STEP_1);
    repeat (20) turn_encoder(epc_pkg::IDX_TEMPO, 1'b1);
    select_step(epc_pkg::STEP_10);
    repeat (30) turn_encoder(epc_pkg::IDX_TEMPO, 1'b0);
  endtask

  // The sender holds off until the pipeline is empty, then resumes.
  task automatic test_pause_until_drained();
    turn_encoder(epc_pkg::IDX_RES, 1'b1);
    press_button(epc_pkg::IDX_PAGE);
    wait_all_reports();
    turn_encoder(epc_pkg::IDX_PAGE, 1'b1);
    turn_encoder(epc_pkg::IDX_RES, 1'b0);
  endtask

  // Mostly whole detents with random targets, plus buttons, noise and broken turns.
  task automatic test_random_traffic();
    int kind, len, segment;
    logic cw;
    logic [2:0] idx;
    while (requests_sent < ITEM_TARGET) begin
      segment = requests_sent / SEGMENT_LEN;
      case (segment % 3)
        0: begin sender_idle = 1'b1; receiver_idle = 1'b1; end
        1: begin sender_idle = 1'b0; receiver_idle = 1'b0; end
        default: begin sender_idle = 1'b0; receiver_idle = 1'b1; end
      endcase
      kind = $urandom_range(0, 99);
      idx  = 3'($urandom_range(0, 7));
      cw   = 1'($urandom_range(0, 1));
      if (kind < 65) begin
        len = $urandom_range(1, 12);
        repeat (len) turn_encoder(idx, cw);
      end else if (kind < 82) begin
        press_button(idx);
      end else if (kind < 92) begin
        len = $urandom_range(1, 6);
        repeat (len)
          send_request(1'b0, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
      end else if (kind < 98) begin
        len = $urandom_range(1, 3);
        for (int k = 3; k > 3 - len; k--)
          send_request(1'b0, idx, cw ? epc_pkg::PAT_HI[k] : epc_pkg::PAT_LO[k],
                       cw ? epc_pkg::PAT_LO[k] : epc_pkg::PAT_HI[k]);
      end else begin
        wait_all_reports();
      end
    end
  endtask

  // Test sequence.
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    reset_prediction();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_directed_operations();
    test_tempo_limits();
    test_pause_until_drained();
    test_random_traffic();

    wait_all_reports();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests and %0d checked reports, %0d clockwise and %0d ccw steps.",
             requests_sent, reports_checked, cw_steps, ccw_steps);
    $display("Tempo spanned %0d to %0d bpm under random gaps on both streams.",
             tempo_low, tempo_high);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/epc_pkg.sv
src/epc_front.sv
src/epc_queue.sv
src/epc_back.sv
src/encoder_parameter_controller.sv
tb/sv/testbench.sv
